// ===== hdl/decimal_plain_value_decoder_macros.svh =====
// Assertion macros for the decimal plain value decoder.
// Depends on a clock i_clk and an active-low reset i_rst_n in the including scope.
`ifndef DECIMAL_PLAIN_VALUE_DECODER_MACROS_SVH
`define DECIMAL_PLAIN_VALUE_DECODER_MACROS_SVH

// Condition holds in the same cycle
`define DPVD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition holds in the next cycle
`define DPVD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/dpvd_pkg.sv =====
// Types, codes and helper functions of the decimal plain value decoder.
// No dependencies.
`timescale 1ns / 1ps
package dpvd_pkg;
    localparam int unsigned CELLS     = 128;
    localparam int unsigned MUL_CELLS = 64;

    typedef enum logic [1:0] {
        KIND_CONTENT    = 2'd0,
        KIND_NULL       = 2'd1,
        KIND_FILT_CONT  = 2'd2,
        KIND_FILT_NULL  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        FMT_BYTES = 2'd0,
        FMT_INT32 = 2'd1,
        FMT_INT64 = 2'd2,
        FMT_SPARE = 2'd3
    } t_format;

    typedef enum logic [1:0] {
        SCL_NONE = 2'd0,
        SCL_MUL  = 2'd1,
        SCL_DIV  = 2'd2
    } t_scale;

    typedef enum logic [1:0] {
        W32  = 2'd0,
        W64  = 2'd1,
        W128 = 2'd2
    } t_width;

    typedef enum logic [2:0] {
        REG_SOURCE_FORMAT  = 3'd0,
        REG_BYTE_LENGTH    = 3'd1,
        REG_SCALE_MODE     = 3'd2,
        REG_DECIMAL_FACTOR = 3'd3,
        REG_TARGET_WIDTH   = 3'd4
    } t_reg;

    typedef struct packed {
        logic         valid;
        logic         nul;
        t_width       w;
        t_scale       mode;
        logic         neg;
        logic [127:0] a;
        logic [127:0] b;
        logic [63:0]  rem;
    } t_cell;

    typedef struct packed {
        logic [1:0]  source_format;
        logic [4:0]  byte_length;
        logic [1:0]  scale_mode;
        logic [63:0] decimal_factor;
        logic [1:0]  target_width;
    } t_cfg;

    function automatic logic [127:0] fit(input logic [127:0] v, input t_width w);
        logic [127:0] r;
        case (w)
            W32:     r = {{96{v[31]}}, v[31:0]};
            W64:     r = {{64{v[63]}}, v[63:0]};
            default: r = v;
        endcase
        return r;
    endfunction
endpackage

// ===== hdl/dpvd_if.sv =====
// Channel interfaces of the decimal plain value decoder: input, result, register write.
// Depends on nothing.
`timescale 1ns / 1ps
interface dpvd_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [63:0] raw_high;
    logic [63:0] raw_low;
    modport source (output valid, kind, raw_high, raw_low, input ready);
    modport sink   (input valid, kind, raw_high, raw_low, output ready);
endinterface

interface dpvd_out_if;
    logic        valid;
    logic        ready;
    logic        is_null;
    logic [63:0] result_high;
    logic [63:0] result_low;
    modport source (output valid, is_null, result_high, result_low, input ready);
    modport sink   (input valid, is_null, result_high, result_low, output ready);
endinterface

interface dpvd_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/decimal_plain_value_decoder.sv =====
// Decimal plain value decoder: one slot enters per cycle while the chain advances; the result leaves after
// the front stage, 128 scaling cells and the output register.
// The whole chain advances together whenever the output register is free or being taken,
// so the sustained rate is one item per cycle. Depends on dpvd_pkg, dpvd_if, dpvd_front,
// dpvd_cell and the macros header.
`timescale 1ns / 1ps
`include "decimal_plain_value_decoder_macros.svh"
module decimal_plain_value_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dpvd_in_if.sink    i_in,
    dpvd_out_if.source o_out,
    dpvd_cfg_if.sink   i_cfg
);
    dpvd_pkg::t_cfg   r_cfg;
    dpvd_pkg::t_cell  chain [0:dpvd_pkg::CELLS];
    logic             adv;
    logic             r_out_valid;
    logic             r_out_null;
    dpvd_pkg::t_width r_out_w;
    logic [127:0]     r_out_val, n_out_val;
    logic [127:0]     q;

    assign adv         = !r_out_valid || o_out.ready;
    assign i_in.ready  = adv;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.source_format  <= 2'd0;
            r_cfg.byte_length    <= 5'd16;
            r_cfg.scale_mode     <= 2'd0;
            r_cfg.decimal_factor <= 64'd1;
            r_cfg.target_width   <= 2'd2;
        end else if (i_cfg.valid) begin
            case (dpvd_pkg::t_reg'(i_cfg.index))
                dpvd_pkg::REG_SOURCE_FORMAT:  r_cfg.source_format  <= i_cfg.data[1:0];
                dpvd_pkg::REG_BYTE_LENGTH:    r_cfg.byte_length    <= i_cfg.data[4:0];
                dpvd_pkg::REG_SCALE_MODE:     r_cfg.scale_mode     <= i_cfg.data[1:0];
                dpvd_pkg::REG_DECIMAL_FACTOR: r_cfg.decimal_factor <= i_cfg.data;
                dpvd_pkg::REG_TARGET_WIDTH:   r_cfg.target_width   <= i_cfg.data[1:0];
                default: ;
            endcase
        end
    end

    dpvd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (adv),
        .i_take     (i_in.valid),
        .i_kind     (i_in.kind),
        .i_raw_high (i_in.raw_high),
        .i_raw_low  (i_in.raw_low),
        .i_cfg      (r_cfg),
        .o_cell     (chain[0])
    );

    for (genvar g = 0; g < dpvd_pkg::CELLS; g++) begin : g_cell
        dpvd_cell #(.IDX(g)) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (adv),
            .i_factor (r_cfg.decimal_factor),
            .i_cell   (chain[g]),
            .o_cell   (chain[g+1])
        );
    end

    always_comb begin
        q = chain[dpvd_pkg::CELLS].a;
        if (chain[dpvd_pkg::CELLS].mode == dpvd_pkg::SCL_DIV) begin
            if (r_cfg.decimal_factor == 64'd0) q = '0;
            else if (chain[dpvd_pkg::CELLS].neg) q = ~q + 128'd1;
        end
        n_out_val = dpvd_pkg::fit(q, chain[dpvd_pkg::CELLS].w);
        if (chain[dpvd_pkg::CELLS].nul) n_out_val = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= chain[dpvd_pkg::CELLS].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_null <= chain[dpvd_pkg::CELLS].nul;
            r_out_w    <= chain[dpvd_pkg::CELLS].w;
            r_out_val  <= n_out_val;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.is_null     = r_out_null;
    assign o_out.result_high = r_out_val[127:64];
    assign o_out.result_low  = r_out_val[63:0];

    `DPVD_ASSERT_NOW(a_null_zero, r_out_valid && r_out_null, r_out_val == 128'd0, "null slot with nonzero value")
    `DPVD_ASSERT_NOW(a_w32_ext, r_out_valid && r_out_w == dpvd_pkg::W32, r_out_val[127:32] == {96{r_out_val[31]}}, "32-bit result not sign-extended")
    `DPVD_ASSERT_NEXT(a_filter_drop, adv && i_in.valid && i_in.kind[1], !chain[0].valid, "filtered slot entered the chain")
endmodule

// ===== hdl/dpvd_front.sv =====
// Front stage: decode stored bytes to a signed value and load the first cell.
// Depends on dpvd_pkg.
`timescale 1ns / 1ps
module dpvd_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_take,
    input  logic [1:0]         i_kind,
    input  logic [63:0]        i_raw_high,
    input  logic [63:0]        i_raw_low,
    input  dpvd_pkg::t_cfg     i_cfg,
    output dpvd_pkg::t_cell    o_cell
);
    dpvd_pkg::t_cell r_cell, n_cell;
    logic [4:0]   len;
    logic [3:0]   sh;
    logic [127:0] v;
    logic [63:0]  le;
    dpvd_pkg::t_width tw, sw;
    dpvd_pkg::t_scale md;

    always_comb begin
        len = i_cfg.byte_length;
        if (len == 5'd0) len = 5'd1;
        if (len > 5'd16) len = 5'd16;
        sh = 4'(5'd16 - len);
        case (i_cfg.target_width)
            2'd0:    tw = dpvd_pkg::W32;
            2'd1:    tw = dpvd_pkg::W64;
            default: tw = dpvd_pkg::W128;
        endcase
        case (i_cfg.scale_mode)
            2'd1:    md = dpvd_pkg::SCL_MUL;
            2'd2:    md = dpvd_pkg::SCL_DIV;
            default: md = dpvd_pkg::SCL_NONE;
        endcase
        for (int i = 0; i < 8; i++) begin
            le[8*i +: 8] = i_raw_high[56 - 8*i +: 8];
        end
        case (dpvd_pkg::t_format'(i_cfg.source_format))
            dpvd_pkg::FMT_INT32, dpvd_pkg::FMT_INT64: begin
                if (dpvd_pkg::t_format'(i_cfg.source_format) == dpvd_pkg::FMT_INT32)
                    v = {{96{le[31]}}, le[31:0]};
                else
                    v = {{64{le[63]}}, le};
                sw = (len <= 5'd8) ? dpvd_pkg::W64 : dpvd_pkg::W128;
                if (tw < sw) sw = tw;
            end
            default: begin
                v  = 128'($signed({i_raw_high, i_raw_low}) >>> {sh, 3'b000});
                v  = dpvd_pkg::fit(v, tw);
                sw = tw;
            end
        endcase
        n_cell       = '0;
        n_cell.valid = i_take && (i_kind == dpvd_pkg::KIND_CONTENT
                                  || i_kind == dpvd_pkg::KIND_NULL);
        n_cell.nul   = (i_kind == dpvd_pkg::KIND_NULL);
        n_cell.w     = sw;
        n_cell.mode  = md;
        n_cell.neg   = v[127];
        case (md)
            dpvd_pkg::SCL_MUL: begin
                n_cell.a = '0;
                n_cell.b = v;
            end
            dpvd_pkg::SCL_DIV: n_cell.a = v[127] ? (~v + 128'd1) : v;
            default:           n_cell.a = v;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;
endmodule

// ===== hdl/dpvd_cell.sv =====
// Scaling cell: a multiply bit step, a divide bit step or a pass-through.
// Depends on dpvd_pkg.
`timescale 1ns / 1ps
module dpvd_cell #(
    parameter int unsigned IDX = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic [63:0]        i_factor,
    input  dpvd_pkg::t_cell    i_cell,
    output dpvd_pkg::t_cell    o_cell
);
    dpvd_pkg::t_cell r_cell, n_cell;
    logic [64:0] rs;

    always_comb begin
        n_cell = i_cell;
        rs     = {i_cell.rem, i_cell.a[127]};
        case (i_cell.mode)
            dpvd_pkg::SCL_MUL: begin
                if (IDX < dpvd_pkg::MUL_CELLS) begin
                    n_cell.a = {i_cell.a[126:0], 1'b0}
                             + (i_factor[(dpvd_pkg::MUL_CELLS - 1 - IDX) % dpvd_pkg::MUL_CELLS]
                                ? i_cell.b : 128'd0);
                end
            end
            dpvd_pkg::SCL_DIV: begin
                if (rs >= {1'b0, i_factor}) begin
                    n_cell.rem = 64'(rs - {1'b0, i_factor});
                    n_cell.a   = {i_cell.a[126:0], 1'b1};
                end else begin
                    n_cell.rem = rs[63:0];
                    n_cell.a   = {i_cell.a[126:0], 1'b0};
                end
            end
            default: n_cell = i_cell;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;
endmodule
